// ----- hdl/bra_pkg.sv -----
// Shared types and constants of the bitmap run allocator.
package bra_pkg;

	// map geometry
	localparam int MAP_BYTES_DEF = 512;
	localparam int BIDX_W        = 10;            // byte index, follows length_bytes width
	localparam int BIT_W         = BIDX_W + 3;    // bit index within the map in use
	localparam int CFG_IDX_W     = 8;
	localparam logic [BIDX_W-1:0] LEN_RESET = 10'd512;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEN  = 8'd1;

	typedef enum logic [1:0] {
		OP_TEST  = 2'd0,
		OP_WRITE = 2'd1,
		OP_ALLOC = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_RUN  = 2'd1,
		ST_OUTSIDE = 2'd2,
		ST_BAD_LEN = 2'd3
	} status_t;

	typedef struct packed {
		op_t         opcode;
		logic [31:0] bit_index;
		logic        write_value;
		logic [12:0] run_length;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic        bit_value;
		logic [31:0] run_start;
	} res_t;

	// outcome of scanning one map byte
	typedef struct packed {
		logic             found;
		logic [2:0]       pos;
		logic [BIT_W-1:0] run_out;
	} scan_t;

endpackage

// ----- hdl/bra_mem.sv -----
// Map store: one write port, one read port, registered read data.
module bra_mem #(
	parameter int DEPTH = bra_pkg::MAP_BYTES_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/bra_scan.sv -----
// Run finder over one map byte: extends the clear run and spots the run's end.
module bra_scan (
	input  logic [7:0]                 byte_in,
	input  logic [bra_pkg::BIT_W-1:0]  run_in,
	input  logic [bra_pkg::BIT_W-1:0]  count,
	output bra_pkg::scan_t             scan
);

	logic [bra_pkg::BIT_W-1:0] run_j [8];
	logic [7:0]                hit;

	// run length after each bit: distance from the last used bit, or carried run
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			logic       seen;
			logic [2:0] last;
			seen = 1'b0;
			last = 3'd0;
			for (int i = 0; i <= j; i++) begin
				if (byte_in[i]) begin
					seen = 1'b1;
					last = 3'(i);
				end
			end
			if (seen) begin
				run_j[j] = bra_pkg::BIT_W'(3'(j) - last);
			end else begin
				run_j[j] = run_in + bra_pkg::BIT_W'(j + 1);
			end
			hit[j] = (run_j[j] == count);
		end
	end

	// lowest bit at which the run reaches the count
	always_comb begin
		scan.found   = |hit;
		scan.pos     = 3'd0;
		scan.run_out = run_j[7];
		for (int j = 7; j >= 0; j--) begin
			if (hit[j]) begin
				scan.pos = 3'(j);
			end
		end
	end

endmodule

// ----- hdl/bitmap_run_allocator.sv -----
// Top level of the bitmap run allocator: control sequencer around the map store.
//
//  channel   direction  handshake                    payload
//  command   in         start & !busy                cmd (bra_pkg::cmd_t)
//  result    out        done, one cycle, no stall    result (bra_pkg::res_t)
//  config    in         cfg_valid & cfg_ready        cfg_index, cfg_data
//
// After reset the store is cleared one byte a cycle, with busy high.
// Test and write do a store read, then give the result or write back; invalid
// items, bad lengths and the unused opcode answer the cycle after acceptance.
// Allocation scans one map byte per cycle through the store's read port, then
// sets the run one byte per cycle.
// Results cannot be held off; config is always ready.
module bitmap_run_allocator #(
	parameter int MAP_BYTES = bra_pkg::MAP_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  bra_pkg::cmd_t                   cmd,
	output logic                            done,
	output bra_pkg::res_t                   result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bra_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data
);

	localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int BW = bra_pkg::BIDX_W;
	localparam int NW = bra_pkg::BIT_W;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_TEST,
		S_WRITE,
		S_SCAN,
		S_FILL
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    clr_addr_q;
	logic [31:0]      base_q;
	logic [BW-1:0]    len_q;
	logic [NW-1:0]    rel_q;
	logic             wval_q;
	logic [NW-1:0]    count_q;
	logic [BW-1:0]    scan_addr_q;
	logic [NW-1:0]    run_q;
	logic [NW-1:0]    first_q;
	logic [NW-1:0]    last_q;
	logic [BW-1:0]    fill_addr_q;
	logic             done_q;
	bra_pkg::res_t    res_q;

	logic [BW-1:0]    nbytes;
	logic [NW-1:0]    nbits;
	logic [31:0]      rel_now;
	logic             outside;
	logic             bad_len;
	logic [NW-1:0]    end_now;
	logic [NW-1:0]    first_now;
	logic [BW-1:0]    rd_idx;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [7:0]       mem_wdata;
	logic [7:0]       mem_rdata;
	logic [7:0]       bit_mask;
	logic [7:0]       fill_mask;
	bra_pkg::scan_t   scan;

	// bytes and bits in use
	always_comb begin
		if ({22'd0, len_q} > MAP_BYTES) begin
			nbytes = BW'(MAP_BYTES);
		end else begin
			nbytes = len_q;
		end
		nbits = {nbytes, 3'b000};
	end

	// checks at acceptance
	assign rel_now  = cmd.bit_index - base_q;
	assign outside  = rel_now >= {{(32-NW){1'b0}}, nbits};
	assign bad_len  = (cmd.run_length == '0) || (cmd.run_length > nbits);

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = res_q;

	bra_scan u_scan (
		.byte_in (mem_rdata),
		.run_in  (run_q),
		.count   (count_q),
		.scan    (scan)
	);

	// run bounds once the scan hits
	assign end_now   = {scan_addr_q, scan.pos};
	assign first_now = end_now + NW'(1) - count_q;

	// bits of the current fill byte that lie inside the run
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			logic [NW-1:0] abs_bit;
			abs_bit      = {fill_addr_q, 3'(j)};
			fill_mask[j] = (abs_bit >= first_q) && (abs_bit <= last_q);
		end
	end

	assign bit_mask = 8'd1 << rel_q[2:0];

	// store read address
	always_comb begin
		case (state_q)
			S_IDLE:  rd_idx = (cmd.opcode == bra_pkg::OP_ALLOC) ? '0 : rel_now[NW-1:3];
			S_SCAN:  rd_idx = scan.found ? first_now[NW-1:3] : scan_addr_q + BW'(1);
			S_FILL:  rd_idx = fill_addr_q + BW'(1);
			default: rd_idx = rel_q[NW-1:3];
		endcase
	end

	// store write port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(rel_q[NW-1:3]);
		mem_wdata = wval_q ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = 8'd0;
			end
			S_WRITE: begin
				mem_we = 1'b1;
			end
			S_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(fill_addr_q);
				mem_wdata = mem_rdata | fill_mask;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	bra_mem #(
		.DEPTH (MAP_BYTES),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (AW'(rd_idx)),
		.rdata (mem_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			len_q  <= bra_pkg::LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bra_pkg::REG_BASE: base_q <= cfg_data;
				bra_pkg::REG_LEN:  len_q  <= cfg_data[BW-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_addr_q <= '0;
			done_q     <= 1'b0;
			res_q      <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					done_q     <= 1'b0;
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(MAP_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						rel_q   <= rel_now[NW-1:0];
						wval_q  <= cmd.write_value;
						count_q <= cmd.run_length;
						unique case (cmd.opcode)
							bra_pkg::OP_TEST, bra_pkg::OP_WRITE: begin
								if (outside) begin
									done_q <= 1'b1;
									res_q  <= '{status: bra_pkg::ST_OUTSIDE,
										bit_value: 1'b0, run_start: 32'd0};
								end else begin
									done_q  <= 1'b0;
									res_q   <= '0;
									state_q <= (cmd.opcode == bra_pkg::OP_TEST) ? S_TEST
									                                            : S_WRITE;
								end
							end
							bra_pkg::OP_ALLOC: begin
								if (bad_len) begin
									done_q <= 1'b1;
									res_q  <= '{status: bra_pkg::ST_BAD_LEN,
										bit_value: 1'b0, run_start: 32'd0};
								end else begin
									done_q      <= 1'b0;
									res_q       <= '0;
									scan_addr_q <= '0;
									run_q       <= '0;
									state_q     <= S_SCAN;
								end
							end
							default: begin
								done_q <= 1'b1;
								res_q  <= '0;
							end
						endcase
					end else begin
						done_q <= 1'b0;
					end
				end
				S_TEST: begin
					done_q          <= 1'b1;
					res_q.bit_value <= mem_rdata[rel_q[2:0]];
					state_q         <= S_IDLE;
				end
				S_WRITE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (scan.found) begin
						done_q      <= 1'b0;
						first_q     <= first_now;
						last_q      <= end_now;
						fill_addr_q <= first_now[NW-1:3];
						state_q     <= S_FILL;
					end else if (scan_addr_q == nbytes - BW'(1)) begin
						done_q       <= 1'b1;
						res_q.status <= bra_pkg::ST_NO_RUN;
						state_q      <= S_IDLE;
					end else begin
						done_q      <= 1'b0;
						scan_addr_q <= scan_addr_q + BW'(1);
						run_q       <= scan.run_out;
					end
				end
				S_FILL: begin
					if (fill_addr_q == last_q[NW-1:3]) begin
						done_q          <= 1'b1;
						res_q.run_start <= {{(32-NW){1'b0}}, first_q} + base_q;
						state_q         <= S_IDLE;
					end else begin
						done_q      <= 1'b0;
						fill_addr_q <= fill_addr_q + BW'(1);
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// no result while the store is still being cleared
	a_no_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !done_q)
		else $error("result during clearing pass");

	// the scan never walks past the bytes in use
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> scan_addr_q < nbytes)
		else $error("scan beyond map in use");

	// the fill never runs past the last byte of the run
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL |-> (fill_addr_q <= last_q[NW-1:3]) && (first_q <= last_q))
		else $error("fill beyond run");

	// a failed item reports no run start
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && res_q.status != bra_pkg::ST_OK |-> res_q.run_start == '0 && !res_q.bit_value)
		else $error("failed item carries data");

endmodule

// ----- verif/bitmap_run_allocator_test.sv -----
// Self-checking testbench of the bitmap run allocator: commands, map predictor, result check.
module bitmap_run_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bra_pkg::*;

	localparam int unsigned QUIET_LIMIT = 20000;  // cycles with no accepted item, result or register write
	localparam int unsigned TAIL_CYCLES = 1100;   // longest allocation plus margin
	localparam int unsigned NUM_PHASES  = 9;
	localparam int unsigned SHOW_LIMIT  = 10;

	// Map predictor and store of expected results
	class alloc_scoreboard;
		logic [7:0]  usage [MAP_BYTES_DEF];
		logic [31:0] base;
		logic [9:0]  len_bytes;
		res_t        awaited [$];
		int unsigned mismatches;

		function new();
			foreach (usage[i]) usage[i] = '0;
			base       = '0;
			len_bytes  = LEN_RESET;
			mismatches = 0;
		endfunction

		function int unsigned bits_in_use();
			int unsigned n;
			n = len_bytes;
			if (n > MAP_BYTES_DEF)
				n = MAP_BYTES_DEF;
			return n * 8;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				REG_BASE: base = data;
				REG_LEN:  len_bytes = data[9:0];
				default: ;
			endcase
		endfunction

		// next map state and answer for one command
		function res_t predict_outcome(cmd_t c);
			res_t        r;
			logic [31:0] rel;
			int unsigned nbits, k, run, first;
			bit          found;
			r     = '0;
			rel   = c.bit_index - base;
			nbits = bits_in_use();
			run   = 0;
			first = 0;
			found = 0;
			case (c.opcode)
				OP_TEST: begin
					if (rel >= nbits)
						r.status = ST_OUTSIDE;
					else
						r.bit_value = usage[rel >> 3][rel[2:0]];
				end
				OP_WRITE: begin
					if (rel >= nbits)
						r.status = ST_OUTSIDE;
					else
						usage[rel >> 3][rel[2:0]] = c.write_value;
				end
				OP_ALLOC: begin
					if (c.run_length == 0 || c.run_length > nbits) begin
						r.status = ST_BAD_LEN;
					end else begin
						// lowest run of clear bits, first fit
						for (k = 0; k < nbits && !found; k++) begin
							run = usage[k >> 3][k[2:0]] ? 0 : run + 1;
							if (run == c.run_length) begin
								first = k + 1 - c.run_length;
								found = 1;
							end
						end
						if (!found) begin
							r.status = ST_NO_RUN;
						end else begin
							for (k = first; k < first + c.run_length; k++)
								usage[k >> 3][k[2:0]] = 1'b1;
							r.run_start = first + base;
						end
					end
				end
				default: ;
			endcase
			return r;
		endfunction

		function void note_cmd(cmd_t c);
			awaited.push_back(predict_outcome(c));
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOW_LIMIT)
					$display("[%0t] result with none expected: status %s bit %0b start %h",
						$time, got.status.name(), got.bit_value, got.run_start);
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status || got.bit_value !== want.bit_value ||
					got.run_start !== want.run_start) begin
				mismatches++;
				if (mismatches <= SHOW_LIMIT)
					$display("[%0t] mismatch: expected status %s bit %0b start %h, got status %s bit %0b start %h",
						$time, want.status.name(), want.bit_value, want.run_start,
						got.status.name(), got.bit_value, got.run_start);
			end
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 busy;
	cmd_t                 cmd       = '0;
	logic                 done;
	res_t                 result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data  = '0;
	int unsigned          quiet_cycles = 0;
	alloc_scoreboard      sb;

	bitmap_run_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	// watchdog: any accepted item, result or register write restarts the count
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("bitmap_run_allocator regression: fail");
		$finish;
	end

	function automatic cmd_t mk(op_t op, logic [31:0] idx, logic wv, logic [12:0] n);
		cmd_t c;
		c.opcode      = op;
		c.bit_index   = idx;
		c.write_value = wv;
		c.run_length  = n;
		return c;
	endfunction

	// random command; mostly in-range work, some outside indexes and bad lengths
	function automatic cmd_t make_item(logic [31:0] base, int unsigned nbits);
		cmd_t        c;
		int unsigned pick, lim;
		c.opcode      = OP_TEST;
		c.bit_index   = $urandom;
		c.write_value = 1'($urandom);
		c.run_length  = 13'($urandom);
		lim  = (nbits < 12) ? nbits : 12;
		pick = $urandom_range(99);
		if (pick < 45) begin
			c.opcode = OP_ALLOC;
			pick = $urandom_range(99);
			if (nbits == 0 || pick >= 95)
				c.run_length = ($urandom_range(1) == 0) ? 13'd0
					: 13'($urandom_range(8191, nbits + 1));
			else if (pick < 75)
				c.run_length = 13'($urandom_range(lim, 1));
			else if (pick < 90)
				c.run_length = 13'($urandom_range(nbits, 1));
			else
				c.run_length = 13'(nbits);
		end else if (pick < 88) begin
			c.opcode = (pick < 70) ? OP_WRITE : OP_TEST;
			if (nbits != 0)
				c.bit_index = base + $urandom_range(nbits - 1);
			// bias writes towards freeing so allocations keep finding room
			if ($urandom_range(99) < 75)
				c.write_value = 1'b0;
		end else if (pick < 94) begin
			c.opcode = ($urandom_range(1) == 0) ? OP_WRITE : OP_TEST;
			case ($urandom_range(2))
				0: c.bit_index = base + nbits + $urandom_range(4095);
				1: c.bit_index = base - 1 - $urandom_range(4095);
				default: ;
			endcase
		end else begin
			c.opcode = OP_NOP;
		end
		return c;
	endfunction

	// one command item; start stays high when the next follows at once
	task automatic issue(cmd_t c, int unsigned gap);
		cmd   <= c;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_cmd(c);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain();
		start <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	task automatic set_config(logic [31:0] base, logic [9:0] len);
		cfg_valid <= 1'b1;
		cfg_index <= REG_BASE;
		cfg_data  <= base;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.write_reg(REG_BASE, base);
		cfg_index <= REG_LEN;
		cfg_data  <= {22'd0, len};
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.write_reg(REG_LEN, {22'd0, len});
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] ph_base  [NUM_PHASES];
		logic [9:0]  ph_len   [NUM_PHASES];
		int unsigned ph_items [NUM_PHASES];
		int unsigned ph_idle  [NUM_PHASES];
		cmd_t        directed [$];
		int unsigned nbits, pct, gap;

		sb = new();

		// phase settings: wrap-prone bases, clamped and empty map lengths
		ph_base  = '{32'd0, 32'hFFFF_FFFC, $urandom, 32'd1000, $urandom,
			$urandom, 32'hFFFF_FFFF, $urandom, 32'd0};
		ph_len   = '{10'd512, 10'd1, 10'd4, 10'd1023, 10'd0, 10'd16, 10'd8, 10'd3, 10'd512};
		ph_items = '{110, 130, 140, 110, 50, 140, 140, 140, 100};
		ph_idle  = '{0, 69, 0, 10, 69, 0, 69, 10, 0};

		// directed items on the reset map: base 0, all 4096 bits in use
		directed.push_back(mk(OP_TEST,  32'd0,         1'b1, 13'd0));
		directed.push_back(mk(OP_WRITE, 32'd0,         1'b1, 13'd0));
		directed.push_back(mk(OP_TEST,  32'd0,         1'b0, 13'd8191));
		directed.push_back(mk(OP_WRITE, 32'd4095,      1'b1, 13'd0));
		directed.push_back(mk(OP_TEST,  32'd4095,      1'b0, 13'd0));
		directed.push_back(mk(OP_TEST,  32'd4096,      1'b0, 13'd0));
		directed.push_back(mk(OP_WRITE, 32'hFFFF_FFFF, 1'b1, 13'd0));
		directed.push_back(mk(OP_ALLOC, 32'd0,         1'b0, 13'd0));
		directed.push_back(mk(OP_ALLOC, 32'd0,         1'b0, 13'd4097));
		directed.push_back(mk(OP_ALLOC, 32'hFFFF_FFFF, 1'b1, 13'd8191));
		directed.push_back(mk(OP_ALLOC, 32'd0,         1'b0, 13'd4095));
		directed.push_back(mk(OP_ALLOC, 32'd0,         1'b0, 13'd1));
		directed.push_back(mk(OP_ALLOC, 32'd0,         1'b0, 13'd3));
		directed.push_back(mk(OP_WRITE, 32'd2,         1'b0, 13'd0));
		directed.push_back(mk(OP_ALLOC, 32'd0,         1'b0, 13'd1));
		directed.push_back(mk(OP_NOP,   32'hFFFF_FFFF, 1'b1, 13'd8191));
		directed.push_back(mk(OP_TEST,  32'hFFFF_FFFF, 1'b0, 13'd0));
		directed.push_back(mk(OP_WRITE, 32'd4095,      1'b0, 13'd0));
		directed.push_back(mk(OP_ALLOC, 32'd0,         1'b0, 13'd4092));
		directed.push_back(mk(OP_TEST,  32'd4,         1'b0, 13'd0));
		directed.push_back(mk(OP_TEST,  32'd5,         1'b0, 13'd0));
		directed.push_back(mk(OP_ALLOC, 32'd0,         1'b0, 13'd4096));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int unsigned p = 0; p < NUM_PHASES; p++) begin
			if (p != 0) begin
				drain();
				set_config(ph_base[p], ph_len[p]);
			end
			nbits = ((ph_len[p] > MAP_BYTES_DEF) ? MAP_BYTES_DEF : ph_len[p]) * 8;
			if (p == 0)
				foreach (directed[i])
					issue(directed[i], $urandom_range(1));
			for (int unsigned i = 0; i < ph_items[p]; i++) begin
				// a stretch without idling inside every phase
				pct = (i >= 40 && i < 60) ? 0 : ph_idle[p];
				gap = ($urandom_range(99) < pct) ? $urandom_range(6, 1) : 0;
				if (i == 70)
					gap = 1;
				issue(make_item(ph_base[p], nbits), gap);
				// hold off until the block has answered everything
				if (i == 70)
					while (sb.awaited.size() != 0) @(posedge clk);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.awaited.size() == 0)
			$display("bitmap_run_allocator regression: pass");
		else
			$display("bitmap_run_allocator regression: fail");
		$finish;
	end

endmodule
